FILE: rtl/core/bdsn_pkg.sv
// Shared types and constants for the box decode, sort and NMS block.
package bdsn_pkg;

   // Register indexes on the csr port
   localparam logic [7:0] CSR_INV_SCALE = 8'd0;
   localparam logic [7:0] CSR_SCORE_MIN = 8'd1;
   localparam logic [7:0] CSR_IOU_LIMIT = 8'd2;
   localparam logic [7:0] CSR_MAX_BOXES = 8'd3;

   // Register reset values
   localparam logic [15:0] INV_SCALE_RST = 16'd4096;
   localparam logic [15:0] SCORE_MIN_RST = 16'd32768;
   localparam logic [15:0] IOU_LIMIT_RST = 16'd29491;
   localparam logic [6:0]  MAX_BOXES_RST = 7'd10;

   // One stored candidate
   typedef struct packed {
      logic [15:0] score;
      logic [63:0] geom;    // left | top<<16 | width<<32 | height<<48
      logic [63:0] kps_lo;
      logic [63:0] kps_hi;
   } cand_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;      // capture request fields
      logic latch_cand;    // capture scaled candidate
      logic wr_shift;      // move read entry to write address
      logic wr_new;        // write new candidate at write address
      logic wr_kill;       // clear alive bit at write address
      logic latch_boxi;    // capture reference box for NMS
      logic out_load_pend; // hold read entry as pending result
      logic out_emit;      // drive one result transaction
      logic out_valid;
      logic out_last;
      logic out_dropped;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic qualify;       // candidate passes threshold and size
      logic rd_score_ge;   // read entry score >= new score
      logic rd_alive;      // alive bit of read entry
      logic suppress;      // IoU compare result
   } dp_sts_type;

endpackage

FILE: rtl/core/box_decode_sort_nms.sv
// Detection decode, score-sorted candidate store and greedy IoU NMS.
// Each accepted detection is scaled, captured and qualified; a stored one then walks down from
// the tail past lower scores and is written in place. One detection is taken at a time.
// A frame end then runs the greedy suppression sweep and the readout; results cannot be stalled.
// Synchronous active-high reset clears the configuration registers, the controller state, the
// candidate count and the overflow flag; the store itself needs no clear.
module box_decode_sort_nms
   import bdsn_pkg::*;
#(
   parameter int MAX_CANDIDATES = 256,
   parameter int MAX_OUT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_raw_cx,
   input  logic [15:0] req_raw_cy,
   input  logic [15:0] req_raw_w,
   input  logic [15:0] req_raw_h,
   input  logic [15:0] req_raw_score,
   input  logic [63:0] req_raw_kps_a,
   input  logic [63:0] req_raw_kps_b,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   output logic        rsp_box_valid,
   output logic [15:0] rsp_box_score,
   output logic [15:0] rsp_box_left,
   output logic [15:0] rsp_box_top,
   output logic [15:0] rsp_box_width,
   output logic [15:0] rsp_box_height,
   output logic [63:0] rsp_box_kps_a,
   output logic [63:0] rsp_box_kps_b,
   output logic        rsp_box_last,
   output logic        rsp_dropped,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_CANDIDATES);
   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
   localparam int K_W   = $clog2(MAX_OUT + 1);

   // Configuration registers
   logic [15:0] inv_scale_ff, score_min_ff, iou_limit_ff;
   logic [6:0]  max_boxes_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_scale_ff <= INV_SCALE_RST;
         score_min_ff <= SCORE_MIN_RST;
         iou_limit_ff <= IOU_LIMIT_RST;
         max_boxes_ff <= MAX_BOXES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INV_SCALE: inv_scale_ff <= csr_data;
            CSR_SCORE_MIN: score_min_ff <= csr_data;
            CSR_IOU_LIMIT: iou_limit_ff <= csr_data;
            CSR_MAX_BOXES: max_boxes_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Report limit: zero acts as one, capped at MAX_OUT
   logic [K_W-1:0] limit;
   always_comb begin
      if (max_boxes_ff == 7'd0)                 limit = K_W'(1);
      else if (32'(max_boxes_ff) > MAX_OUT)     limit = K_W'(MAX_OUT);
      else                                      limit = K_W'(max_boxes_ff);
   end

   dp_cmd_type       cmd;
   dp_sts_type       sts;
   logic [IDX_W-1:0] rd_addr, wr_addr;

   bdsn_ctrl #(
      .MAX_CANDIDATES (MAX_CANDIDATES),
      .IDX_W          (IDX_W),
      .CNT_W          (CNT_W),
      .K_W            (K_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_frame_end (req_frame_end),
      .limit         (limit),
      .sts           (sts),
      .busy          (busy),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr)
   );

   bdsn_datapath #(
      .IDX_W (IDX_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .inv_scale      (inv_scale_ff),
      .score_min      (score_min_ff),
      .iou_limit      (iou_limit_ff),
      .req_raw_cx     (req_raw_cx),
      .req_raw_cy     (req_raw_cy),
      .req_raw_w      (req_raw_w),
      .req_raw_h      (req_raw_h),
      .req_raw_score  (req_raw_score),
      .req_raw_kps_a  (req_raw_kps_a),
      .req_raw_kps_b  (req_raw_kps_b),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_box_valid  (rsp_box_valid),
      .rsp_box_score  (rsp_box_score),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .rsp_box_kps_a  (rsp_box_kps_a),
      .rsp_box_kps_b  (rsp_box_kps_b),
      .rsp_box_last   (rsp_box_last),
      .rsp_dropped    (rsp_dropped)
   );

`ifndef NO_ASSERTIONS
   // An accepted transaction keeps the block busy next cycle
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   // The last result of a frame is not followed directly by another
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_box_last) |=> !rsp_valid)
      else $error("result right after frame's last result");

   // An empty result only ever closes a frame
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_box_valid) |-> rsp_box_last)
      else $error("empty result not marked last");
`endif

endmodule

FILE: rtl/core/bdsn_datapath.sv
// Datapath: scaling, candidate store, IoU compare and result registers.
module bdsn_datapath
   import bdsn_pkg::*;
#(
   parameter int IDX_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [IDX_W-1:0]  rd_addr,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [15:0]       inv_scale,
   input  logic [15:0]       score_min,
   input  logic [15:0]       iou_limit,
   input  logic [15:0]       req_raw_cx,
   input  logic [15:0]       req_raw_cy,
   input  logic [15:0]       req_raw_w,
   input  logic [15:0]       req_raw_h,
   input  logic [15:0]       req_raw_score,
   input  logic [63:0]       req_raw_kps_a,
   input  logic [63:0]       req_raw_kps_b,
   output dp_sts_type        sts,
   output logic              rsp_valid,
   output logic              rsp_box_valid,
   output logic [15:0]       rsp_box_score,
   output logic [15:0]       rsp_box_left,
   output logic [15:0]       rsp_box_top,
   output logic [15:0]       rsp_box_width,
   output logic [15:0]       rsp_box_height,
   output logic [63:0]       rsp_box_kps_a,
   output logic [63:0]       rsp_box_kps_b,
   output logic              rsp_box_last,
   output logic              rsp_dropped
);

   localparam int DEPTH = 1 << IDX_W;

   // Request capture
   logic [15:0]  cx_ff, cy_ff, w_ff, h_ff, score_ff;
   logic [127:0] kps_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cx_ff    <= req_raw_cx;
         cy_ff    <= req_raw_cy;
         w_ff     <= req_raw_w;
         h_ff     <= req_raw_h;
         score_ff <= req_raw_score;
         kps_ff   <= {req_raw_kps_b, req_raw_kps_a};
      end
   end

   // Scaling multipliers, one register stage
   logic [31:0] pcx_ff, pcy_ff, pw_ff, ph_ff;
   logic [32:0] lane_prod_ff [8];
   logic [7:0]  lane_neg_ff;
   logic [16:0] lane_mag [8];
   logic [7:0]  lane_sign;

   for (genvar g = 0; g < 8; g++) begin : g_lane
      logic [15:0] raw;
      assign raw          = kps_ff[16*g +: 16];
      assign lane_mag[g]  = raw[15] ? 17'(17'h10000 - {1'b0, raw}) : {1'b0, raw};
      assign lane_sign[g] = raw[15];
   end

   always_ff @(posedge clock) begin
      pcx_ff <= cx_ff * inv_scale;
      pcy_ff <= cy_ff * inv_scale;
      pw_ff  <= w_ff * inv_scale;
      ph_ff  <= h_ff * inv_scale;
      for (int k = 0; k < 8; k++) begin
         lane_prod_ff[k] <= lane_mag[k] * inv_scale;
         lane_neg_ff[k]  <= lane_sign[k];
      end
   end

   function automatic logic [15:0] sat_u(input logic [31:0] p);
      logic [19:0] q;
      q = p[31:12];
      return (|q[19:16]) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic logic [15:0] sat_lane(input logic [32:0] p, input logic neg);
      logic [20:0] q;
      logic [15:0] r;
      q = p[32:12];
      if (!neg) r = (q > 21'd32767) ? 16'h7FFF : q[15:0];
      else      r = (q > 21'd32768) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
      return r;
   endfunction

   function automatic logic [15:0] edge_pos(input logic [15:0] c, input logic [15:0] s);
      logic [17:0] t;
      t = {1'b0, c, 1'b0} - {2'b00, s};
      return (!t[17] && (t != 18'd0)) ? t[16:1] : 16'd0;
   endfunction

   logic [15:0]  scx, scy, sw, sh;
   logic [127:0] skps;
   assign scx = sat_u(pcx_ff);
   assign scy = sat_u(pcy_ff);
   assign sw  = sat_u(pw_ff);
   assign sh  = sat_u(ph_ff);
   always_comb begin
      for (int k = 0; k < 8; k++) skps[16*k +: 16] = sat_lane(lane_prod_ff[k], lane_neg_ff[k]);
   end

   // Candidate register
   cand_type cand_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch_cand) begin
         cand_ff.score  <= score_ff;
         cand_ff.geom   <= {sh, sw, edge_pos(scy, sh), edge_pos(scx, sw)};
         cand_ff.kps_lo <= skps[63:0];
         cand_ff.kps_hi <= skps[127:64];
      end
   end

   assign sts.qualify = (cand_ff.score > score_min) &&
                        (cand_ff.geom[47:32] != 16'd0) && (cand_ff.geom[63:48] != 16'd0);

   // Candidate store and alive bits
   cand_type mem [DEPTH];
   logic     alive_mem [DEPTH];
   cand_type rd_data_ff;
   logic     rd_alive_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_shift)    mem[wr_addr] <= rd_data_ff;
      else if (cmd.wr_new) mem[wr_addr] <= cand_ff;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_shift)                    alive_mem[wr_addr] <= rd_alive_ff;
      else if (cmd.wr_new)                 alive_mem[wr_addr] <= 1'b1;
      else if (cmd.wr_kill)                alive_mem[wr_addr] <= 1'b0;
      rd_alive_ff <= alive_mem[rd_addr];
   end

   assign sts.rd_score_ge = rd_data_ff.score >= cand_ff.score;
   assign sts.rd_alive    = rd_alive_ff;

   // IoU: reference box in integer pixels
   logic [11:0] bx_ff, by_ff, bw_ff, bh_ff;
   logic [23:0] area_i_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch_boxi) begin
         bx_ff <= rd_data_ff.geom[15:4];
         by_ff <= rd_data_ff.geom[31:20];
         bw_ff <= rd_data_ff.geom[47:36];
         bh_ff <= rd_data_ff.geom[63:52];
      end
      area_i_ff <= bw_ff * bh_ff;
   end

   logic [11:0] jx, jy, jw, jh;
   logic [12:0] xa, ya, xe, ye, iw, ih, ei_x, ej_x, ei_y, ej_y;
   assign jx = rd_data_ff.geom[15:4];
   assign jy = rd_data_ff.geom[31:20];
   assign jw = rd_data_ff.geom[47:36];
   assign jh = rd_data_ff.geom[63:52];
   assign ei_x = {1'b0, bx_ff} + {1'b0, bw_ff};
   assign ej_x = {1'b0, jx} + {1'b0, jw};
   assign ei_y = {1'b0, by_ff} + {1'b0, bh_ff};
   assign ej_y = {1'b0, jy} + {1'b0, jh};
   assign xa = (bx_ff > jx) ? {1'b0, bx_ff} : {1'b0, jx};
   assign ya = (by_ff > jy) ? {1'b0, by_ff} : {1'b0, jy};
   assign xe = (ei_x < ej_x) ? ei_x : ej_x;
   assign ye = (ei_y < ej_y) ? ei_y : ej_y;
   assign iw = (xe > xa) ? 13'(xe - xa) : 13'd0;
   assign ih = (ye > ya) ? 13'(ye - ya) : 13'd0;

   // Stage 1: intersection and area products
   logic [25:0] inter_ff, inter2_ff;
   logic [23:0] area_j_ff;
   logic [25:0] uni;
   logic [41:0] thr_prod_ff;
   logic        uni_nz_ff;

   always_ff @(posedge clock) begin
      inter_ff  <= iw * ih;
      area_j_ff <= jw * jh;
   end

   // Stage 2: union and threshold product
   assign uni = 26'({2'b00, area_i_ff} + {2'b00, area_j_ff} - inter_ff);
   always_ff @(posedge clock) begin
      thr_prod_ff <= iou_limit * uni;
      inter2_ff   <= inter_ff;
      uni_nz_ff   <= uni != 26'd0;
   end

   assign sts.suppress = uni_nz_ff && ({inter2_ff, 16'd0} > thr_prod_ff);

   // Result registers
   cand_type pend_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load_pend) pend_ff <= rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= cmd.out_emit;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_emit) begin
         rsp_box_valid  <= cmd.out_valid;
         rsp_box_last   <= cmd.out_last;
         rsp_dropped    <= cmd.out_dropped;
         rsp_box_score  <= cmd.out_valid ? pend_ff.score : 16'd0;
         rsp_box_left   <= cmd.out_valid ? pend_ff.geom[15:0] : 16'd0;
         rsp_box_top    <= cmd.out_valid ? pend_ff.geom[31:16] : 16'd0;
         rsp_box_width  <= cmd.out_valid ? pend_ff.geom[47:32] : 16'd0;
         rsp_box_height <= cmd.out_valid ? pend_ff.geom[63:48] : 16'd0;
         rsp_box_kps_a  <= cmd.out_valid ? pend_ff.kps_lo : 64'd0;
         rsp_box_kps_b  <= cmd.out_valid ? pend_ff.kps_hi : 64'd0;
      end
   end

endmodule

FILE: rtl/core/bdsn_ctrl.sv
// Controller: sequences insertion, suppression sweep and result readout.
module bdsn_ctrl
   import bdsn_pkg::*;
#(
   parameter int MAX_CANDIDATES = 256,
   parameter int IDX_W = 8,
   parameter int CNT_W = 9,
   parameter int K_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_frame_end,
   input  logic [K_W-1:0]   limit,
   input  dp_sts_type       sts,
   output logic             busy,
   output dp_cmd_type       cmd,
   output logic [IDX_W-1:0] rd_addr,
   output logic [IDX_W-1:0] wr_addr
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL    = 4'd1;
   localparam logic [3:0] ST_CAND   = 4'd2;
   localparam logic [3:0] ST_QUAL   = 4'd3;
   localparam logic [3:0] ST_SH_RD  = 4'd4;
   localparam logic [3:0] ST_SH_CMP = 4'd5;
   localparam logic [3:0] ST_WR_NEW = 4'd6;
   localparam logic [3:0] ST_I_RD   = 4'd7;
   localparam logic [3:0] ST_I_CHK  = 4'd8;
   localparam logic [3:0] ST_J_RD   = 4'd9;
   localparam logic [3:0] ST_J_S1   = 4'd10;
   localparam logic [3:0] ST_J_S2   = 4'd11;
   localparam logic [3:0] ST_J_S3   = 4'd12;
   localparam logic [3:0] ST_O_RD   = 4'd13;
   localparam logic [3:0] ST_O_CHK  = 4'd14;
   localparam logic [3:0] ST_O_END  = 4'd15;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CANDIDATES);

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, jm1;
   logic [K_W-1:0]   k_ff, k_in;
   logic             pend_ff, pend_in, ovf_ff, ovf_in, fend_ff, fend_in;

   assign jm1 = j_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         fend_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         fend_ff  <= fend_in;
         pend_ff  <= pend_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

   // Read address follows the loop that owns the port
   always_comb begin
      case (state_ff)
         ST_SH_RD, ST_SH_CMP:                   rd_addr = jm1[IDX_W-1:0];
         ST_J_RD, ST_J_S1, ST_J_S2, ST_J_S3:    rd_addr = j_ff[IDX_W-1:0];
         default:                               rd_addr = i_ff[IDX_W-1:0];
      endcase
   end
   assign wr_addr = j_ff[IDX_W-1:0];

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      fend_in  = fend_ff;
      pend_in  = pend_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd      = '0;
      cmd.out_dropped = ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               fend_in      = req_frame_end;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_CAND;
         ST_CAND: begin
            cmd.latch_cand = 1'b1;
            state_in       = ST_QUAL;
         end
         ST_QUAL: begin
            i_in = '0;
            if (!sts.qualify) begin
               state_in = fend_ff ? ST_I_RD : ST_IDLE;
            end else if (cnt_ff == CNT_FULL) begin
               ovf_in   = 1'b1;
               state_in = fend_ff ? ST_I_RD : ST_IDLE;
            end else begin
               j_in     = cnt_ff;
               state_in = ST_SH_RD;
            end
         end
         // Walk down from the tail, moving lower scores one slot up
         ST_SH_RD: state_in = (j_ff == '0) ? ST_WR_NEW : ST_SH_CMP;
         ST_SH_CMP: begin
            if (sts.rd_score_ge) begin
               state_in = ST_WR_NEW;
            end else begin
               cmd.wr_shift = 1'b1;
               j_in         = jm1;
               state_in     = ST_SH_RD;
            end
         end
         ST_WR_NEW: begin
            cmd.wr_new = 1'b1;
            cnt_in     = cnt_ff + CNT_W'(1);
            state_in   = fend_ff ? ST_I_RD : ST_IDLE;
         end
         // Suppression sweep, outer index i
         ST_I_RD: begin
            if (i_ff >= cnt_ff) begin
               i_in     = '0;
               k_in     = '0;
               pend_in  = 1'b0;
               state_in = ST_O_RD;
            end else begin
               state_in = ST_I_CHK;
            end
         end
         ST_I_CHK: begin
            if (sts.rd_alive) begin
               cmd.latch_boxi = 1'b1;
               j_in           = i_ff + CNT_W'(1);
               state_in       = ST_J_RD;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_I_RD;
            end
         end
         // Inner index j
         ST_J_RD: begin
            if (j_ff >= cnt_ff) begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_I_RD;
            end else begin
               state_in = ST_J_S1;
            end
         end
         ST_J_S1: state_in = ST_J_S2;
         ST_J_S2: state_in = ST_J_S3;
         ST_J_S3: begin
            cmd.wr_kill = sts.rd_alive && sts.suppress;
            j_in        = j_ff + CNT_W'(1);
            state_in    = ST_J_RD;
         end
         // Readout with one pending result so the last one is marked
         ST_O_RD: begin
            if (i_ff >= cnt_ff || k_ff == limit) state_in = ST_O_END;
            else                                 state_in = ST_O_CHK;
         end
         ST_O_CHK: begin
            if (sts.rd_alive) begin
               cmd.out_emit      = pend_ff;
               cmd.out_valid     = 1'b1;
               cmd.out_load_pend = 1'b1;
               pend_in           = 1'b1;
               k_in              = k_ff + K_W'(1);
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = ST_O_RD;
         end
         ST_O_END: begin
            cmd.out_emit  = 1'b1;
            cmd.out_valid = pend_ff;
            cmd.out_last  = 1'b1;
            cnt_in        = '0;
            ovf_in        = 1'b0;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: tb/sv/box_decode_sort_nms_checker.sv
// Scoreboard for the box decode, sort and NMS block: predicts frame results and compares.
module box_decode_sort_nms_checker
   import bdsn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [15:0] req_raw_cx,
   input  logic [15:0] req_raw_cy,
   input  logic [15:0] req_raw_w,
   input  logic [15:0] req_raw_h,
   input  logic [15:0] req_raw_score,
   input  logic [63:0] req_raw_kps_a,
   input  logic [63:0] req_raw_kps_b,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_box_valid,
   input  logic [15:0] rsp_box_score,
   input  logic [15:0] rsp_box_left,
   input  logic [15:0] rsp_box_top,
   input  logic [15:0] rsp_box_width,
   input  logic [15:0] rsp_box_height,
   input  logic [63:0] rsp_box_kps_a,
   input  logic [63:0] rsp_box_kps_b,
   input  logic        rsp_box_last,
   input  logic        rsp_dropped,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam int STORE_DEPTH = 256;
   localparam int OUT_LIMIT   = 64;

   typedef struct {
      logic [15:0] score;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] width;
      logic [15:0] height;
      logic [63:0] kps_a;
      logic [63:0] kps_b;
      bit          alive;
   } stored_box_type;

   typedef struct {
      bit          valid;
      logic [15:0] score;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] width;
      logic [15:0] height;
      logic [63:0] kps_a;
      logic [63:0] kps_b;
      bit          last;
      bit          dropped;
   } frame_box_type;

   logic [15:0]    inv_scale, score_min, iou_limit;
   logic [6:0]     max_boxes;
   stored_box_type sorted_boxes[$];
   bit             store_overflow;
   frame_box_type  expected_boxes[$];

   // (v * scale) >> 12, saturated
   function automatic logic [15:0] scale_len(logic [15:0] v);
      logic [32:0] p;
      p = ({17'd0, v} * {17'd0, inv_scale}) >> 12;
      return (p > 33'hFFFF) ? 16'hFFFF : p[15:0];
   endfunction

   // signed lane: magnitude scaled, truncation toward zero, saturated
   function automatic logic [15:0] scale_lane(logic [15:0] raw);
      longint s, mag, r;
      s = longint'($signed(raw));
      mag = (s < 0) ? -s : s;
      mag = (mag * longint'(inv_scale)) / 4096;
      r = (s < 0) ? -mag : mag;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic logic [63:0] scale_kps(logic [63:0] v);
      return {scale_lane(v[63:48]), scale_lane(v[47:32]),
              scale_lane(v[31:16]), scale_lane(v[15:0])};
   endfunction

   function automatic logic [15:0] low_edge(logic [15:0] c, logic [15:0] s);
      longint t;
      t = 2 * longint'(c) - longint'(s);
      return (t > 0) ? 16'(t >> 1) : 16'd0;
   endfunction

   // IoU test on whole-pixel rectangles, no division
   function automatic bit boxes_overlap(stored_box_type a, stored_box_type b);
      longint x1, y1, w1, h1, x2, y2, w2, h2, xa, ya, xb, yb, iw, ih, inter, uni;
      x1 = a.left >> 4;  y1 = a.top >> 4;  w1 = a.width >> 4;  h1 = a.height >> 4;
      x2 = b.left >> 4;  y2 = b.top >> 4;  w2 = b.width >> 4;  h2 = b.height >> 4;
      xa = (x1 > x2) ? x1 : x2;
      ya = (y1 > y2) ? y1 : y2;
      xb = ((x1 + w1 < x2 + w2) ? x1 + w1 : x2 + w2) - 1;
      yb = ((y1 + h1 < y2 + h2) ? y1 + h1 : y2 + h2) - 1;
      iw = xb - xa + 1;
      ih = yb - ya + 1;
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter = iw * ih;
      uni = w1 * h1 + w2 * h2 - inter;
      if (uni <= 0) return 0;
      return inter * 65536 > longint'(iou_limit) * uni;
   endfunction

   // sorted insert of one detection
   task automatic insert_detection();
      stored_box_type nb;
      logic [15:0] cx, cy;
      int pos;
      cx = scale_len(req_raw_cx);
      cy = scale_len(req_raw_cy);
      nb.width = scale_len(req_raw_w);
      nb.height = scale_len(req_raw_h);
      nb.score = req_raw_score;
      if (nb.score <= score_min || nb.width == 0 || nb.height == 0) return;
      if (sorted_boxes.size() >= STORE_DEPTH) begin
         store_overflow = 1;
         return;
      end
      nb.left = low_edge(cx, nb.width);
      nb.top = low_edge(cy, nb.height);
      nb.kps_a = scale_kps(req_raw_kps_a);
      nb.kps_b = scale_kps(req_raw_kps_b);
      nb.alive = 1;
      pos = 0;
      while (pos < sorted_boxes.size() && sorted_boxes[pos].score >= nb.score) pos++;
      sorted_boxes.insert(pos, nb);
   endtask

   // greedy suppression and readout at frame end
   task automatic close_frame();
      int limit, emitted;
      frame_box_type fb;
      for (int i = 0; i < sorted_boxes.size(); i++) begin
         if (!sorted_boxes[i].alive) continue;
         for (int j = i + 1; j < sorted_boxes.size(); j++)
            if (sorted_boxes[j].alive && boxes_overlap(sorted_boxes[i], sorted_boxes[j]))
               sorted_boxes[j].alive = 0;
      end
      limit = (max_boxes == 0) ? 1 : int'(max_boxes);
      if (limit > OUT_LIMIT) limit = OUT_LIMIT;
      emitted = 0;
      for (int i = 0; i < sorted_boxes.size() && emitted < limit; i++) begin
         if (!sorted_boxes[i].alive) continue;
         fb.valid = 1;
         fb.score = sorted_boxes[i].score;
         fb.left = sorted_boxes[i].left;
         fb.top = sorted_boxes[i].top;
         fb.width = sorted_boxes[i].width;
         fb.height = sorted_boxes[i].height;
         fb.kps_a = sorted_boxes[i].kps_a;
         fb.kps_b = sorted_boxes[i].kps_b;
         fb.last = 0;
         fb.dropped = store_overflow;
         expected_boxes.insert(expected_boxes.size(), fb);
         emitted++;
      end
      if (emitted == 0) begin
         fb = '{valid: 0, score: 0, left: 0, top: 0, width: 0, height: 0,
                kps_a: 0, kps_b: 0, last: 0, dropped: store_overflow};
         expected_boxes.insert(expected_boxes.size(), fb);
      end
      expected_boxes[expected_boxes.size() - 1].last = 1;
      sorted_boxes.delete();
      store_overflow = 0;
   endtask

   // compare one result transaction with the oldest expectation
   task automatic check_result();
      frame_box_type e;
      bit bad;
      if (expected_boxes.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("unexpected result: score %h last %b",
                                        rsp_box_score, rsp_box_last);
         return;
      end
      e = expected_boxes.pop_front();
      bad = (rsp_box_valid !== e.valid) || (rsp_box_score !== e.score) ||
            (rsp_box_left !== e.left) || (rsp_box_top !== e.top) ||
            (rsp_box_width !== e.width) || (rsp_box_height !== e.height) ||
            (rsp_box_kps_a !== e.kps_a) || (rsp_box_kps_b !== e.kps_b) ||
            (rsp_box_last !== e.last) || (rsp_dropped !== e.dropped);
      if (bad) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("mismatch exp: v%b s%h l%h t%h w%h h%h ka%h kb%h last%b drop%b",
                     e.valid, e.score, e.left, e.top, e.width, e.height,
                     e.kps_a, e.kps_b, e.last, e.dropped);
            $display("         act: v%b s%h l%h t%h w%h h%h ka%h kb%h last%b drop%b",
                     rsp_box_valid, rsp_box_score, rsp_box_left, rsp_box_top,
                     rsp_box_width, rsp_box_height, rsp_box_kps_a, rsp_box_kps_b,
                     rsp_box_last, rsp_dropped);
         end
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // watch all three channels
   always @(posedge clock) begin
      if (reset) begin
         inv_scale = INV_SCALE_RST;
         score_min = SCORE_MIN_RST;
         iou_limit = IOU_LIMIT_RST;
         max_boxes = MAX_BOXES_RST;
         sorted_boxes.delete();
         expected_boxes.delete();
         store_overflow = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INV_SCALE: inv_scale = csr_data;
               CSR_SCORE_MIN: score_min = csr_data;
               CSR_IOU_LIMIT: iou_limit = csr_data;
               CSR_MAX_BOXES: max_boxes = csr_data[6:0];
               default: ;
            endcase
         end
         if (rsp_valid) check_result();
         if (start && !busy) begin
            insert_detection();
            if (req_frame_end) close_frame();
         end
      end
      pending = expected_boxes.size();
   end

endmodule

FILE: tb/sv/box_decode_sort_nms_tb.sv
// Testbench top for the box decode, sort and NMS block: stimulus, phases and verdict.
module box_decode_sort_nms_tb;
   import bdsn_pkg::*;

   localparam logic [7:0] CSR_UNMAPPED = 8'd9;

   logic        clock = 0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_raw_cx, req_raw_cy, req_raw_w, req_raw_h, req_raw_score;
   logic [63:0] req_raw_kps_a, req_raw_kps_b;
   logic        req_frame_end;
   logic        rsp_valid, rsp_box_valid, rsp_box_last, rsp_dropped;
   logic [15:0] rsp_box_score, rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height;
   logic [63:0] rsp_box_kps_a, rsp_box_kps_b;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;
   int          fail_count, pending;
   int          idle_pct;
   logic [15:0] cur_conf;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   box_decode_sort_nms dut (.*);

   box_decode_sort_nms_checker checker_i (.*);

   // one detection transaction, then maybe a gap
   task automatic send_detection(logic [15:0] cx, logic [15:0] cy, logic [15:0] w,
                                 logic [15:0] h, logic [15:0] score, logic [63:0] ka,
                                 logic [63:0] kb, logic fe);
      req_raw_cx <= cx;
      req_raw_cy <= cy;
      req_raw_w <= w;
      req_raw_h <= h;
      req_raw_score <= score;
      req_raw_kps_a <= ka;
      req_raw_kps_b <= kb;
      req_frame_end <= fe;
      start <= 1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // register write while the block is idle
   task automatic write_reg(logic [7:0] idx, logic [15:0] val);
      start <= 0;
      @(negedge clock);
      while (pending != 0 || busy) @(negedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 0;
      if (idx == CSR_SCORE_MIN) cur_conf = val;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random detection, mostly clustered so suppression and ties happen
   task automatic send_random(logic fe);
      logic [15:0] cx, cy, w, h, sc;
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         cx = $urandom; cy = $urandom; w = $urandom; h = $urandom; sc = $urandom;
      end else begin
         cx = 16'(16 * (200 + $urandom_range(40)));
         cy = 16'(16 * (100 + $urandom_range(40)));
         w = (pick < 15) ? 16'($urandom_range(3)) : 16'(16 * $urandom_range(1, 60));
         h = 16'(16 * $urandom_range(1, 60));
         if (pick < 40) sc = 16'(40000 + 10000 * $urandom_range(2));
         else sc = (cur_conf == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(cur_conf, 65535));
      end
      send_detection(cx, cy, w, h, sc, rand64(), rand64(), fe);
   endtask

   initial begin
      int frame_len, budget;
      reset <= 1;
      start <= 0;
      req_raw_cx <= 0; req_raw_cy <= 0; req_raw_w <= 0; req_raw_h <= 0;
      req_raw_score <= 0; req_raw_kps_a <= 0; req_raw_kps_b <= 0; req_frame_end <= 0;
      csr_valid <= 0; csr_index <= 0; csr_data <= 0;
      idle_pct = 0;
      cur_conf = SCORE_MIN_RST;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed frame at reset settings: thresholds, clamps, ties, overlap
      send_detection(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     64'h8000_7FFF_FFFF_0001, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_detection(16'd800, 16'd800, 16'd320, 16'd320, 16'd0, 0, 0, 0);
      send_detection(16'd800, 16'd800, 16'd320, 16'd320, 16'd32768, 0, 0, 0);
      send_detection(16'd800, 16'd800, 16'd320, 16'd320, 16'd32769, 64'h1234, 0, 0);
      send_detection(16'd800, 16'd800, 16'd0, 16'd320, 16'd60000, 0, 0, 0);
      send_detection(16'd0, 16'd0, 16'd320, 16'd320, 16'd50000, 0, 64'h8000_8000, 0);
      send_detection(16'd0, 16'd0, 16'd320, 16'd320, 16'd50000, 0, 0, 0);
      send_detection(16'd3000, 16'd3000, 16'd640, 16'd640, 16'd50000, 0, 0, 0);
      send_detection(16'd3008, 16'd3008, 16'd640, 16'd640, 16'd55000, 0, 0, 1);
      // frame with nothing kept
      send_detection(16'd800, 16'd800, 16'd320, 16'd320, 16'd100, 0, 0, 1);
      // saturating scale
      write_reg(CSR_INV_SCALE, 16'hFFFF);
      write_reg(CSR_IOU_LIMIT, 16'd0);
      send_detection(16'h4000, 16'h0100, 16'h2000, 16'h0010, 16'hF000,
                     64'h8000_7FFF_0100_FF00, 64'h0001_FFFF_4000_C000, 0);
      send_detection(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'hE000, rand64(), 0, 1);
      // tiny scale: sizes vanish
      write_reg(CSR_INV_SCALE, 16'd1);
      write_reg(CSR_MAX_BOXES, 16'd0);
      write_reg(CSR_UNMAPPED, 16'hFFFF);
      send_detection(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     64'h8000_7FFF_8001_0001, 0, 0);
      send_detection(16'h0FFF, 16'h0FFF, 16'h0FFF, 16'h0FFF, 16'hFFFF, 0, 0, 1);
      write_reg(CSR_MAX_BOXES, 16'd127);
      write_reg(CSR_SCORE_MIN, 16'hFFFF);
      send_detection(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1);

      // random phases: no idling, sender idle, no idling again, mixed
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 79 : (phase == 3) ? 12 : 0;
         case ($urandom_range(3))
            0: write_reg(CSR_INV_SCALE, 16'd4096);
            1: write_reg(CSR_INV_SCALE, 16'hFFFF);
            2: write_reg(CSR_INV_SCALE, 16'd1);
            default: write_reg(CSR_INV_SCALE, 16'($urandom_range(2048, 8192)));
         endcase
         case ($urandom_range(3))
            0: write_reg(CSR_SCORE_MIN, 16'd0);
            1: write_reg(CSR_SCORE_MIN, 16'd65000);
            default: write_reg(CSR_SCORE_MIN, 16'($urandom_range(30000, 45000)));
         endcase
         case ($urandom_range(3))
            0: write_reg(CSR_IOU_LIMIT, 16'd0);
            1: write_reg(CSR_IOU_LIMIT, 16'hFFFF);
            default: write_reg(CSR_IOU_LIMIT, 16'($urandom));
         endcase
         case ($urandom_range(4))
            0: write_reg(CSR_MAX_BOXES, 16'd1);
            1: write_reg(CSR_MAX_BOXES, 16'd64);
            2: write_reg(CSR_MAX_BOXES, 16'd0);
            default: write_reg(CSR_MAX_BOXES, 16'($urandom_range(2, 10)));
         endcase
         budget = 4;
         while (budget > 0) begin
            frame_len = $urandom_range(1, 12);
            for (int k = 1; k <= frame_len; k++) send_random(k == frame_len);
            budget -= frame_len;
         end
      end

      // store overflow: falling scores keep the insert short, boxes never overlap
      idle_pct = 0;
      write_reg(CSR_INV_SCALE, 16'd4096);
      write_reg(CSR_SCORE_MIN, 16'd0);
      write_reg(CSR_MAX_BOXES, 16'd64);
      for (int k = 0; k < 257; k++)
         send_detection(16'(640 * (k % 16) + 320), 16'(640 * (k / 16) + 320),
                        16'd256, 16'd256, 16'(1000 - k), rand64(), rand64(), k == 256);

      start <= 0;
      @(negedge clock);
      while (pending != 0 || busy) @(negedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // overall time limit
   initial begin
      #40000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
